/* design/wlft_pkg.sv */
// ----------------------------------------------------------------------------
// wlft_pkg
// Shared types, widths, constants and helper functions for the leg/world
// frame transform pipeline.
// ----------------------------------------------------------------------------
package wlft_pkg;

  // coordinate and angle formats
  localparam int COORD_BITS    = 32;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

  localparam int CW        = COORD_BITS;
  localparam int OW        = CW + 1;          // negated offsets reach +2^(CW-1)
  localparam int AW        = CW + 2;          // point minus translation
  localparam int MW        = CW + 1;          // magnitude of the above
  localparam int TW        = 32;              // Q1.30 trig values
  localparam int TRIG_FRAC = 30;
  localparam int PW        = MW + TW;         // product magnitude
  localparam int RW        = PW + 1 - TRIG_FRAC;
  localparam int EW        = RW + 1;
  localparam int SUM_W     = EW + 2;
  localparam int TURN_W    = 32;
  localparam int ZW        = TURN_W;
  localparam int CFG_IDX_W = 2;
  localparam int LEG_W     = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] off_t;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [ZW-1:0] zang_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER_X,
    CFG_OUTER_Y,
    CFG_MIDDLE_X,
    CFG_MIDDLE_Y
  } cfg_idx_t;

  typedef enum logic [LEG_W-1:0] {
    LEG_0,
    LEG_1,
    LEG_2,
    LEG_3,
    LEG_4,
    LEG_5
  } leg_t;

  localparam logic [LEG_W-1:0] LAST_LEG = LEG_5;

  localparam logic OP_LEG_TO_WORLD = 1'b0;
  localparam logic OP_WORLD_TO_LEG = 1'b1;

  localparam trig_t TRIG_ONE    = 32'sd1073741824;
  localparam trig_t TRIG_HALF   = 32'sd536870912;
  localparam trig_t TRIG_R3H    = 32'sd929887697;
  localparam trig_t CORDIC_GAIN = 32'sh26DD3B6A;

  // atan(2^-i) in 2^32-per-turn units
  localparam zang_t ATAN_TURN [0:ATAN_COUNT-1] = '{
    32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2E,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
  };

  typedef struct packed {
    logic                  operation;
    logic [LEG_W-1:0]      leg_index;
    coord_t                point_x;
    coord_t                point_y;
    coord_t                point_z;
    coord_t                robot_x;
    coord_t                robot_y;
    coord_t                robot_z;
    logic [ANGLE_BITS-1:0] heading;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   bad_leg;
  } out_item_t;

  // item context carried alongside the arithmetic
  typedef struct packed {
    logic             op;
    logic [LEG_W-1:0] leg;
    coord_t           px;
    coord_t           py;
    coord_t           pz;
    coord_t           rx;
    coord_t           ry;
    coord_t           rz;
    trig_t            hc;
    trig_t            hs;
  } side_t;

  // operands of one rotate/translate step
  typedef struct packed {
    logic   inv;
    coord_t px;
    coord_t py;
    trig_t  c;
    trig_t  s;
    off_t   tx;
    off_t   ty;
  } rot_op_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } rot_res_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
    off_t  tx;
    off_t  ty;
  } leg_geom_t;

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // fixed mounting of each leg: angle as cos/sin, offset with its signs
  function automatic leg_geom_t leg_geom(input logic [LEG_W-1:0] leg,
                                         input coord_t ox, input coord_t oy,
                                         input coord_t mx, input coord_t my);
    leg_geom_t g;
    off_t      oxe;
    off_t      oye;
    off_t      mxe;
    off_t      mye;
    oxe = OW'(ox);
    oye = OW'(oy);
    mxe = OW'(mx);
    mye = OW'(my);
    case (leg)
      LEG_0: begin
        g.c = TRIG_R3H;   g.s = TRIG_HALF;   g.tx = -oxe; g.ty = oye;
      end
      LEG_1: begin
        g.c = TRIG_R3H;   g.s = -TRIG_HALF;  g.tx = oxe;  g.ty = oye;
      end
      LEG_2: begin
        g.c = '0;         g.s = TRIG_ONE;    g.tx = -mxe; g.ty = mye;
      end
      LEG_3: begin
        g.c = '0;         g.s = -TRIG_ONE;   g.tx = mxe;  g.ty = mye;
      end
      LEG_4: begin
        g.c = -TRIG_R3H;  g.s = TRIG_HALF;   g.tx = -oxe; g.ty = -oye;
      end
      default: begin
        g.c = -TRIG_R3H;  g.s = -TRIG_HALF;  g.tx = oxe;  g.ty = -oye;
      end
    endcase
    return g;
  endfunction

endpackage

/* design/world_leg_frame_transform.sv */
// ----------------------------------------------------------------------------
// world_leg_frame_transform
// Converts a point between a leg frame and the world frame of a six-legged
// body: heading CORDIC, then two rotate-and-translate steps, then z and
// saturation into the output register.
// ----------------------------------------------------------------------------
// Pipeline: 17 CORDIC stages, two 6-stage rotate steps, one output register.
// Throughput: one item per cycle; a stalled output holds each stage only
//   once the stage behind it is full, so bubbles are squeezed out.
// Reset: synchronous, active low; clears all valid bits and the offset
//   registers.
module world_leg_frame_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wlft_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wlft_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [wlft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlft_pkg::CW-1:0]     cfg_wdata
);
  import wlft_pkg::*;

  coord_t outer_x_r, outer_y_r, middle_x_r, middle_y_r;

  logic      cor_valid, cor_ready;
  side_t     cor_side;
  leg_geom_t geom1, geom2;
  rot_op_t   op1, op2;
  logic      s1_valid, s1_ready, s2_valid, s2_ready;
  rot_res_t  s1_res, s2_res;
  side_t     s1_side, s2_side;

  logic               out_valid_r;
  out_item_t          out_item_r, out_item_nxt;
  logic signed [CW:0] z_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_x_r  <= '0;
      outer_y_r  <= '0;
      middle_x_r <= '0;
      middle_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTER_X:  outer_x_r  <= cfg_wdata;
        CFG_OUTER_Y:  outer_y_r  <= cfg_wdata;
        CFG_MIDDLE_X: middle_x_r <= cfg_wdata;
        CFG_MIDDLE_Y: middle_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wlft_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_side  (cor_side)
  );

  // leg to world: leg mount first; world to leg: robot pose first
  always_comb begin
    geom1  = leg_geom(cor_side.leg, outer_x_r, outer_y_r, middle_x_r, middle_y_r);
    op1.px = cor_side.px;
    op1.py = cor_side.py;
    if (cor_side.op == OP_WORLD_TO_LEG) begin
      op1.inv = 1'b1;
      op1.c   = cor_side.hc;
      op1.s   = cor_side.hs;
      op1.tx  = OW'(cor_side.rx);
      op1.ty  = OW'(cor_side.ry);
    end else begin
      op1.inv = 1'b0;
      op1.c   = geom1.c;
      op1.s   = geom1.s;
      op1.tx  = geom1.tx;
      op1.ty  = geom1.ty;
    end
  end

  wlft_rot_step u_step1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_op     (op1),
    .in_side   (cor_side),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_res   (s1_res),
    .out_side  (s1_side)
  );

  always_comb begin
    geom2  = leg_geom(s1_side.leg, outer_x_r, outer_y_r, middle_x_r, middle_y_r);
    op2.px = s1_res.x;
    op2.py = s1_res.y;
    if (s1_side.op == OP_WORLD_TO_LEG) begin
      op2.inv = 1'b1;
      op2.c   = geom2.c;
      op2.s   = geom2.s;
      op2.tx  = geom2.tx;
      op2.ty  = geom2.ty;
    end else begin
      op2.inv = 1'b0;
      op2.c   = s1_side.hc;
      op2.s   = s1_side.hs;
      op2.tx  = OW'(s1_side.rx);
      op2.ty  = OW'(s1_side.ry);
    end
  end

  wlft_rot_step u_step2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_op     (op2),
    .in_side   (s1_side),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_res   (s2_res),
    .out_side  (s2_side)
  );

  assign s2_ready = !out_valid_r || out_ready;

  // z is translated only; an invalid leg drops all coordinates to zero
  always_comb begin
    if (s2_side.op == OP_WORLD_TO_LEG) begin
      z_sum = (CW+1)'(s2_side.pz) - (CW+1)'(s2_side.rz);
    end else begin
      z_sum = (CW+1)'(s2_side.pz) + (CW+1)'(s2_side.rz);
    end
    out_item_nxt.bad_leg = (s2_side.leg > LAST_LEG);
    if (out_item_nxt.bad_leg) begin
      out_item_nxt.out_x = '0;
      out_item_nxt.out_y = '0;
      out_item_nxt.out_z = '0;
    end else begin
      out_item_nxt.out_x = s2_res.x;
      out_item_nxt.out_y = s2_res.y;
      out_item_nxt.out_z = sat_coord(SUM_W'(z_sum));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the pipeline only refuses input when the output is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked output");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_leg) |->
      (out_item.out_x == '0 && out_item.out_y == '0 && out_item.out_z == '0))
    else $error("bad leg result carries non-zero coordinates");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("held result dropped");

endmodule

/* design/wlft_cordic.sv */
// ----------------------------------------------------------------------------
// wlft_cordic
// Pipelined rotation-mode CORDIC giving heading cosine and sine in Q1.30,
// one iteration per register stage, then a quadrant fold-out stage.
// ----------------------------------------------------------------------------
module wlft_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wlft_pkg::in_item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output wlft_pkg::side_t  out_side
);
  import wlft_pkg::*;

  localparam int N = CORDIC_ITERS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [TURN_W-1:0] turn;

  trig_t    x_r    [0:N-1];
  trig_t    y_r    [0:N-1];
  zang_t    z_r    [0:N-1];
  logic [1:0] q_r  [0:N-1];
  in_item_t item_r [0:N-1];
  logic     v_r    [0:N];
  logic     rdy    [0:N+1];
  side_t    side_r;
  side_t    side_nxt;

  assign turn      = {in_item.heading, {(TURN_W-ANGLE_BITS){1'b0}}};
  assign rdy[N+1]  = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N];
  assign out_side  = side_r;

  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    trig_t      x_prev;
    trig_t      y_prev;
    zang_t      z_prev;
    logic [1:0] q_prev;
    in_item_t   item_prev;
    logic       v_prev;
    trig_t      xs;
    trig_t      ys;
    trig_t      x_nxt;
    trig_t      y_nxt;
    zang_t      z_nxt;

    if (k == 0) begin : g_first
      assign x_prev    = CORDIC_GAIN;
      assign y_prev    = '0;
      assign z_prev    = {2'b00, turn[TURN_W-3:0]};
      assign q_prev    = turn[TURN_W-1:TURN_W-2];
      assign item_prev = in_item;
      assign v_prev    = in_valid;
    end else begin : g_next
      assign x_prev    = x_r[k-1];
      assign y_prev    = y_r[k-1];
      assign z_prev    = z_r[k-1];
      assign q_prev    = q_r[k-1];
      assign item_prev = item_r[k-1];
      assign v_prev    = v_r[k-1];
    end

    assign xs = x_prev >>> k;
    assign ys = y_prev >>> k;

    always_comb begin
      if (!z_prev[ZW-1]) begin
        x_nxt = x_prev - ys;
        y_nxt = y_prev + xs;
        z_nxt = z_prev - ATAN_TURN[k];
      end else begin
        x_nxt = x_prev + ys;
        y_nxt = y_prev - xs;
        z_nxt = z_prev + ATAN_TURN[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_prev) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        q_r[k]    <= q_prev;
        item_r[k] <= item_prev;
      end
    end
  end

  // fold the first-quadrant result out to the full turn
  always_comb begin
    side_nxt.op  = item_r[N-1].operation;
    side_nxt.leg = item_r[N-1].leg_index;
    side_nxt.px  = item_r[N-1].point_x;
    side_nxt.py  = item_r[N-1].point_y;
    side_nxt.pz  = item_r[N-1].point_z;
    side_nxt.rx  = item_r[N-1].robot_x;
    side_nxt.ry  = item_r[N-1].robot_y;
    side_nxt.rz  = item_r[N-1].robot_z;
    case (q_r[N-1])
      QUAD_0: begin
        side_nxt.hc = x_r[N-1];
        side_nxt.hs = y_r[N-1];
      end
      QUAD_1: begin
        side_nxt.hc = -y_r[N-1];
        side_nxt.hs = x_r[N-1];
      end
      QUAD_2: begin
        side_nxt.hc = -x_r[N-1];
        side_nxt.hs = -y_r[N-1];
      end
      default: begin
        side_nxt.hc = y_r[N-1];
        side_nxt.hs = -x_r[N-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[N] <= 1'b0;
    end else if (rdy[N]) begin
      v_r[N] <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N] && v_r[N-1]) begin
      side_r <= side_nxt;
    end
  end

endmodule

/* design/wlft_rot_step.sv */
// ----------------------------------------------------------------------------
// wlft_rot_step
// One planar rotate-and-translate step, forward or inverse, in six stages:
// offset, magnitude, multiply, round, sign, sum and saturate.
// ----------------------------------------------------------------------------
module wlft_rot_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wlft_pkg::rot_op_t  in_op,
  input  wlft_pkg::side_t    in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output wlft_pkg::rot_res_t out_res,
  output wlft_pkg::side_t    out_side
);
  import wlft_pkg::*;

  localparam int STAGES = 6;

  logic  v_r    [0:STAGES-1];
  logic  rdy    [0:STAGES];
  side_t side_r [0:STAGES-1];

  // stage 0: subtract translation for the inverse step
  logic signed [AW-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  trig_t c0_r, s0_r;
  off_t  tx0_r, ty0_r;
  logic  inv0_r;
  // stage 1: magnitudes and signs
  logic [MW-1:0] mx_r, my_r;
  logic [TW-1:0] mc_r, ms_r;
  logic  sx_r, sy_r, sc_r, ss_r;
  off_t  tx1_r, ty1_r;
  logic  inv1_r;
  // stage 2: products
  logic [PW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic  nxc_r, nys_r, nxs_r, nyc_r;
  off_t  tx2_r, ty2_r;
  logic  inv2_r;
  // stage 3: round half away from zero on the magnitude
  logic [PW:0]   rnd_xc, rnd_ys, rnd_xs, rnd_yc;
  logic [RW-1:0] rxc_r, rys_r, rxs_r, ryc_r;
  logic  nxc3_r, nys3_r, nxs3_r, nyc3_r;
  off_t  tx3_r, ty3_r;
  logic  inv3_r;
  // stage 4: apply signs
  logic signed [EW-1:0] exc_r, eys_r, exs_r, eyc_r;
  logic signed [EW-1:0] exc_nxt, eys_nxt, exs_nxt, eyc_nxt;
  off_t  tx4_r, ty4_r;
  // stage 5: sum and saturate
  logic signed [SUM_W-1:0] sum_x, sum_y;
  rot_res_t res_r;

  localparam logic [PW:0] HALF_LSB = {{(PW+1-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];
  assign out_valid   = v_r[STAGES-1];
  assign out_res     = res_r;
  assign out_side    = side_r[STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_ctl
    logic  v_prev;
    side_t side_prev;
    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign side_prev = in_side;
    end else begin : g_next
      assign v_prev    = v_r[k-1];
      assign side_prev = side_r[k-1];
    end
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_prev) begin
        side_r[k] <= side_prev;
      end
    end
  end

  always_comb begin
    if (in_op.inv) begin
      ax_nxt = AW'(in_op.px) - AW'(in_op.tx);
      ay_nxt = AW'(in_op.py) - AW'(in_op.ty);
    end else begin
      ax_nxt = AW'(in_op.px);
      ay_nxt = AW'(in_op.py);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      c0_r   <= in_op.c;
      s0_r   <= in_op.s;
      tx0_r  <= in_op.tx;
      ty0_r  <= in_op.ty;
      inv0_r <= in_op.inv;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v_r[0]) begin
      mx_r   <= ax_r[AW-1] ? MW'(-ax_r) : MW'(ax_r);
      my_r   <= ay_r[AW-1] ? MW'(-ay_r) : MW'(ay_r);
      mc_r   <= c0_r[TW-1] ? TW'(-c0_r) : TW'(c0_r);
      ms_r   <= s0_r[TW-1] ? TW'(-s0_r) : TW'(s0_r);
      sx_r   <= ax_r[AW-1];
      sy_r   <= ay_r[AW-1];
      sc_r   <= c0_r[TW-1];
      ss_r   <= s0_r[TW-1];
      tx1_r  <= tx0_r;
      ty1_r  <= ty0_r;
      inv1_r <= inv0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v_r[1]) begin
      pxc_r  <= PW'(mx_r) * PW'(mc_r);
      pys_r  <= PW'(my_r) * PW'(ms_r);
      pxs_r  <= PW'(mx_r) * PW'(ms_r);
      pyc_r  <= PW'(my_r) * PW'(mc_r);
      nxc_r  <= sx_r ^ sc_r;
      nys_r  <= sy_r ^ ss_r;
      nxs_r  <= sx_r ^ ss_r;
      nyc_r  <= sy_r ^ sc_r;
      tx2_r  <= tx1_r;
      ty2_r  <= ty1_r;
      inv2_r <= inv1_r;
    end
  end

  assign rnd_xc = {1'b0, pxc_r} + HALF_LSB;
  assign rnd_ys = {1'b0, pys_r} + HALF_LSB;
  assign rnd_xs = {1'b0, pxs_r} + HALF_LSB;
  assign rnd_yc = {1'b0, pyc_r} + HALF_LSB;

  always_ff @(posedge clk) begin
    if (rdy[3] && v_r[2]) begin
      rxc_r  <= rnd_xc[PW:TRIG_FRAC];
      rys_r  <= rnd_ys[PW:TRIG_FRAC];
      rxs_r  <= rnd_xs[PW:TRIG_FRAC];
      ryc_r  <= rnd_yc[PW:TRIG_FRAC];
      nxc3_r <= nxc_r;
      nys3_r <= nys_r;
      nxs3_r <= nxs_r;
      nyc3_r <= nyc_r;
      tx3_r  <= tx2_r;
      ty3_r  <= ty2_r;
      inv3_r <= inv2_r;
    end
  end

  // forward: x = t + xc - ys, y = t + xs + yc; inverse: x = xc + ys, y = yc - xs
  always_comb begin
    exc_nxt = nxc3_r ? -$signed({1'b0, rxc_r}) : $signed({1'b0, rxc_r});
    eys_nxt = (nys3_r ^ !inv3_r) ? -$signed({1'b0, rys_r}) : $signed({1'b0, rys_r});
    exs_nxt = (nxs3_r ^ inv3_r) ? -$signed({1'b0, rxs_r}) : $signed({1'b0, rxs_r});
    eyc_nxt = nyc3_r ? -$signed({1'b0, ryc_r}) : $signed({1'b0, ryc_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v_r[3]) begin
      exc_r <= exc_nxt;
      eys_r <= eys_nxt;
      exs_r <= exs_nxt;
      eyc_r <= eyc_nxt;
      tx4_r <= inv3_r ? '0 : tx3_r;
      ty4_r <= inv3_r ? '0 : ty3_r;
    end
  end

  assign sum_x = SUM_W'(tx4_r) + SUM_W'(exc_r) + SUM_W'(eys_r);
  assign sum_y = SUM_W'(ty4_r) + SUM_W'(exs_r) + SUM_W'(eyc_r);

  always_ff @(posedge clk) begin
    if (rdy[5] && v_r[4]) begin
      res_r.x <= sat_coord(sum_x);
      res_r.y <= sat_coord(sum_y);
    end
  end

endmodule

/* tb/world_leg_frame_transform_check.sv */
// ----------------------------------------------------------------------------
// world_leg_frame_transform_check
// Watches the point, result and register ports of the leg/world transform.
// Works out the expected result of every accepted item, queues it, and
// compares each delivered result against the oldest queued one.
// ----------------------------------------------------------------------------
module world_leg_frame_transform_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  wlft_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  wlft_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [wlft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlft_pkg::CW-1:0]        cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wlft_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint SIN_ONE   = 64'sd1073741824;
  localparam longint SIN_HALF  = 64'sd536870912;
  localparam longint SIN_R3H   = 64'sd929887697;
  localparam longint ROT_GAIN  = 64'sh26DD3B6A;
  localparam int     ROT_STEPS = 16;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // atan(2^-k) with a full turn as 2^32
  longint angle_step [0:ROT_STEPS-1] = '{
    64'h2000_0000, 64'h12E4_051D, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2E, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2F9, 64'h0000_517C
  };

  longint    outer_x, outer_y, middle_x, middle_y;
  out_item_t expected_q [$];
  out_item_t want;
  int        errs = 0;

  // coordinate times Q1.30, rounded half away from zero
  function automatic longint scale_q30(input longint a, input longint t);
    logic [63:0] am, tm, mag;
    logic        neg;
    neg = (a < 0) != (t < 0);
    am  = (a < 0) ? 64'(-a) : 64'(a);
    tm  = (t < 0) ? 64'(-t) : 64'(t);
    mag = (am >> 32) * tm * 64'd4 +
          (((am & 64'hFFFF_FFFF) * tm + 64'd536870912) >> 30);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) begin
      return COORD_MAX;
    end else if (v < COORD_MIN) begin
      return COORD_MIN;
    end
    return v;
  endfunction

  function automatic void rotate_then_shift(input longint px, input longint py,
                                            input longint c, input longint s,
                                            input longint tx, input longint ty,
                                            output longint ox, output longint oy);
    ox = clamp_coord(tx + scale_q30(px, c) - scale_q30(py, s));
    oy = clamp_coord(ty + scale_q30(px, s) + scale_q30(py, c));
  endfunction

  function automatic void shift_then_unrotate(input longint px, input longint py,
                                              input longint c, input longint s,
                                              input longint tx, input longint ty,
                                              output longint ox, output longint oy);
    longint dx, dy;
    dx = px - tx;
    dy = py - ty;
    ox = clamp_coord(scale_q30(dx, c) + scale_q30(dy, s));
    oy = clamp_coord(scale_q30(dy, c) - scale_q30(dx, s));
  endfunction

  function automatic out_item_t predict_transform(input in_item_t it);
    out_item_t   res;
    longint      px, py, pz, rx, ry, rz;
    longint      lc, ls, lx, ly, hc, hs;
    longint      cx, cy, cz, sx, sy, mx, my, fx, fy, fz;
    logic [31:0] turn;
    int          k;
    res = '0;
    if (it.leg_index > LAST_LEG) begin
      res.bad_leg = 1'b1;
    end else begin
      px = $signed(it.point_x);
      py = $signed(it.point_y);
      pz = $signed(it.point_z);
      rx = $signed(it.robot_x);
      ry = $signed(it.robot_y);
      rz = $signed(it.robot_z);
      case (it.leg_index)
        LEG_0: begin
          lc = SIN_R3H;  ls = SIN_HALF;  lx = -outer_x;  ly = outer_y;
        end
        LEG_1: begin
          lc = SIN_R3H;  ls = -SIN_HALF; lx = outer_x;   ly = outer_y;
        end
        LEG_2: begin
          lc = 0;        ls = SIN_ONE;   lx = -middle_x; ly = middle_y;
        end
        LEG_3: begin
          lc = 0;        ls = -SIN_ONE;  lx = middle_x;  ly = middle_y;
        end
        LEG_4: begin
          lc = -SIN_R3H; ls = SIN_HALF;  lx = -outer_x;  ly = -outer_y;
        end
        default: begin
          lc = -SIN_R3H; ls = -SIN_HALF; lx = outer_x;   ly = -outer_y;
        end
      endcase

      // heading: quadrant from the top bits, the rest through the CORDIC
      turn = {it.heading, 16'h0000};
      cx   = ROT_GAIN;
      cy   = 0;
      cz   = longint'({2'b00, turn[29:0]});
      for (k = 0; k < ROT_STEPS; k++) begin
        sx = cx >>> k;
        sy = cy >>> k;
        if (cz >= 0) begin
          cx -= sy; cy += sx; cz -= angle_step[k];
        end else begin
          cx += sy; cy -= sx; cz += angle_step[k];
        end
      end
      case (turn[31:30])
        QUAD_0:  begin hc = cx;  hs = cy;  end
        QUAD_1:  begin hc = -cy; hs = cx;  end
        QUAD_2:  begin hc = -cx; hs = -cy; end
        default: begin hc = cy;  hs = -cx; end
      endcase

      if (it.operation == OP_LEG_TO_WORLD) begin
        rotate_then_shift(px, py, lc, ls, lx, ly, mx, my);
        rotate_then_shift(mx, my, hc, hs, rx, ry, fx, fy);
        fz = clamp_coord(pz + rz);
      end else begin
        shift_then_unrotate(px, py, hc, hs, rx, ry, mx, my);
        shift_then_unrotate(mx, my, lc, ls, lx, ly, fx, fy);
        fz = clamp_coord(pz - rz);
      end
      res.out_x = coord_t'(fx);
      res.out_y = coord_t'(fy);
      res.out_z = coord_t'(fz);
    end
    return res;
  endfunction

  task automatic check_field(input string label, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, label, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      outer_x  = 0;
      outer_y  = 0;
      middle_x = 0;
      middle_y = 0;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OUTER_X:  outer_x  = $signed(cfg_wdata);
          CFG_OUTER_Y:  outer_y  = $signed(cfg_wdata);
          CFG_MIDDLE_X: middle_x = $signed(cfg_wdata);
          default:      middle_y = $signed(cfg_wdata);
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected item: expected none, got %p", $time, out_item);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_x", $signed(want.out_x), $signed(out_item.out_x));
          check_field("out_y", $signed(want.out_y), $signed(out_item.out_y));
          check_field("out_z", $signed(want.out_z), $signed(out_item.out_z));
          check_field("bad_leg", {63'd0, want.bad_leg}, {63'd0, out_item.bad_leg});
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_transform(in_item));
      end
      outstanding <= expected_q.size();
    end
    fail_count <= errs;
  end

endmodule

/* tb/world_leg_frame_transform_test.sv */
// ----------------------------------------------------------------------------
// world_leg_frame_transform_test
// Drives points through the leg/world transform: a directed set over every
// leg, both directions, quadrant headings and saturating extremes, then
// random points under several mounting-offset settings and idle patterns.
// Checking is done by the attached checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module world_leg_frame_transform_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wlft_pkg::*;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int SETTLE_CYCLES   = 40;
  localparam int QUIET_LIMIT     = 5000;

  localparam logic [31:0] COORD_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_BOT = 32'h8000_0000;
  localparam logic [31:0] ONE       = 32'h0001_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_wdata;
  int                   fail_count;
  int                   outstanding;
  int                   send_idle_pct = 38;
  int                   recv_idle_pct = 48;
  int                   quiet_cycles = 0;

  world_leg_frame_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  world_leg_frame_transform_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // mostly body-sized values, some full range, some hugging the limits
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return coord_t'(longint'($urandom_range(0, 32'h0200_0000)) - 64'sd16777216);
    end else if (pick < 85) begin
      return coord_t'($urandom);
    end else if (pick < 92) begin
      return coord_t'(COORD_TOP - $urandom_range(0, 3));
    end
    return coord_t'(COORD_BOT + $urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] rand_offset();
    return 32'(longint'($urandom_range(0, 32'h0040_0000)) - 64'sd2097152);
  endfunction

  function automatic in_item_t random_point();
    in_item_t it;
    it.operation = $urandom_range(0, 1) ? OP_WORLD_TO_LEG : OP_LEG_TO_WORLD;
    it.leg_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
    it.point_x   = rand_coord();
    it.point_y   = rand_coord();
    it.point_z   = rand_coord();
    it.robot_x   = rand_coord();
    it.robot_y   = rand_coord();
    it.robot_z   = rand_coord();
    it.heading   = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_point(input logic op, input logic [LEG_W-1:0] leg,
                                          input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [31:0] rx,
                                          input logic [31:0] ry, input logic [31:0] rz,
                                          input logic [15:0] hd);
    in_item_t it;
    it.operation = op;
    it.leg_index = leg;
    it.point_x   = px;
    it.point_y   = py;
    it.point_z   = pz;
    it.robot_x   = rx;
    it.robot_y   = ry;
    it.robot_z   = rz;
    it.heading   = hd;
    return it;
  endfunction

  // call at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so a following item can go out without a gap
  task automatic send_point(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offsets(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] mx, input logic [31:0] my);
    cfg_we    = 1'b1;
    cfg_index = CFG_OUTER_X;
    cfg_wdata = ox;
    @(negedge clk);
    cfg_index = CFG_OUTER_Y;
    cfg_wdata = oy;
    @(negedge clk);
    cfg_index = CFG_MIDDLE_X;
    cfg_wdata = mx;
    @(negedge clk);
    cfg_index = CFG_MIDDLE_Y;
    cfg_wdata = my;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int p, l, n;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OUTER_X;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every leg, both directions, headings round the whole turn
    for (l = 0; l < 8; l++) begin
      send_point(make_point(OP_LEG_TO_WORLD, 3'(l), ONE, 2 * ONE, 3 * ONE,
                            10 * ONE, -5 * ONE, ONE / 2, 16'(l * 16'h2000)));
    end
    for (l = 0; l < 8; l++) begin
      send_point(make_point(OP_WORLD_TO_LEG, 3'(l), 25 * ONE / 2, -3 * ONE, ONE,
                            -7 * ONE, 4 * ONE, -2 * ONE, 16'hFFFF - 16'(l * 16'h2000)));
    end
    // saturation at both ends, the zero point and an invalid leg at the limits
    send_point(make_point(OP_LEG_TO_WORLD, LEG_0, COORD_TOP, COORD_TOP, COORD_TOP,
                          COORD_TOP, COORD_TOP, COORD_TOP, 16'h1000));
    send_point(make_point(OP_LEG_TO_WORLD, LEG_5, COORD_BOT, COORD_BOT, COORD_BOT,
                          COORD_BOT, COORD_BOT, COORD_BOT, 16'hC000));
    send_point(make_point(OP_WORLD_TO_LEG, LEG_2, COORD_TOP, COORD_TOP, COORD_TOP,
                          COORD_BOT, COORD_BOT, COORD_BOT, 16'h8000));
    send_point(make_point(OP_WORLD_TO_LEG, LEG_3, COORD_BOT, COORD_BOT, COORD_BOT,
                          COORD_TOP, COORD_TOP, COORD_TOP, 16'hFFFF));
    send_point(make_point(OP_LEG_TO_WORLD, LEG_4, '0, '0, '0, '0, '0, '0, 16'h0000));
    send_point(make_point(OP_WORLD_TO_LEG, LEG_1, '0, '0, '0, '0, '0, '0, 16'h4000));
    send_point(make_point(OP_WORLD_TO_LEG, 3'd7, COORD_TOP, COORD_BOT, COORD_TOP,
                          COORD_BOT, COORD_TOP, COORD_BOT, 16'hFFFF));

    for (p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: write_offsets(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
        1: write_offsets(COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT);
        2: write_offsets(rand_offset(), rand_offset(), rand_offset(), rand_offset());
        3: write_offsets($urandom, $urandom, $urandom, $urandom);
        4: write_offsets(COORD_TOP, COORD_BOT, '0, rand_offset());
        default: write_offsets(rand_offset(), rand_offset(), rand_offset(), rand_offset());
      endcase
      // swap the idle shares after the first two phases, then run flat out
      case (p / 2)
        0: begin send_idle_pct = 38; recv_idle_pct = 48; end
        1: begin send_idle_pct = 48; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_point(random_point());
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/wlft_pkg.sv
design/wlft_cordic.sv
design/wlft_rot_step.sv
design/world_leg_frame_transform.sv
tb/world_leg_frame_transform_check.sv
tb/world_leg_frame_transform_test.sv
